### src/sme_pkg.sv
// Shared constants, codes and handshake types of the slow-motion envelope unit.
`default_nettype none

package sme_pkg;

   // Time and scale widths
   localparam int TIME_BITS       = 24;
   localparam int SCALE_FRAC_BITS = 16;
   localparam int TIMER_BITS      = TIME_BITS + 1;
   localparam int SCALE_BITS      = SCALE_FRAC_BITS + 1;
   localparam int DIVIDEND_BITS   = TIME_BITS + 2;
   localparam int CNT_BITS        = $clog2(SCALE_FRAC_BITS);
   localparam int PROD_BITS       = 2 * SCALE_BITS;
   localparam int FIFTH_SHIFT     = DIVIDEND_BITS + 2;
   localparam int FIFTH_PROD_BITS = 2 * DIVIDEND_BITS;

   // Fixed field widths of the transaction ports
   localparam int CMD_W       = 2;
   localparam int ELAPSED_W   = 20;
   localparam int REQ_SCALE_W = 18;
   localparam int REQ_TIME_W  = 25;
   localparam int PHASE_W     = 2;

   // Scale and time constants
   localparam logic [SCALE_BITS-1:0]    ONE      = {1'b1, {SCALE_FRAC_BITS{1'b0}}};
   localparam logic [TIME_BITS-1:0]     IN_CAP   = TIME_BITS'(60000);
   localparam logic [DIVIDEND_BITS-1:0] OUT_LOW  = DIVIDEND_BITS'(100000);
   localparam logic [DIVIDEND_BITS-1:0] OUT_HIGH = DIVIDEND_BITS'(400000);
   localparam logic [REQ_TIME_W-1:0]    TIME_MAX = REQ_TIME_W'((64'd1 << TIME_BITS) - 64'd1);

   // Rounded-up reciprocal of five, exact for every dividend below 2^DIVIDEND_BITS
   localparam logic [DIVIDEND_BITS-1:0] FIFTH_MUL =
      DIVIDEND_BITS'(((64'd1 << FIFTH_SHIFT) + 64'd4) / 64'd5);

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 2'd0,
      CMD_SIMPLE   = 2'd1,
      CMD_ADVANCED = 2'd2,
      CMD_UNUSED   = 2'd3
   } sme_command_type;

   // Envelope phases
   typedef enum logic [PHASE_W-1:0] {
      PH_NONE      = 2'd0,
      PH_BLEND_IN  = 2'd1,
      PH_HOLD      = 2'd2,
      PH_BLEND_OUT = 2'd3
   } sme_phase_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } sme_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic mul;
      logic commit;
   } sme_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } sme_stat_type;

endpackage

`default_nettype wire

### src/sme_ctrl.sv
// Controller state machine sequencing one transaction through the envelope datapath.
`default_nettype none

module sme_ctrl import sme_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sme_stat_type stat,
   output sme_cmd_type  cmd
);

   sme_state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through prepare, divide, multiply and commit
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = stat.need_div ? ST_DIV : ST_MUL;
         end
         ST_DIV: begin
            if (stat.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_DONE: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/sme_datapath.sv
// Envelope datapath: state registers, shared restoring divider, multiplier, result register.
`default_nettype none

module sme_datapath import sme_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  sme_cmd_type                   cmd,
   output sme_stat_type                  stat,
   input  logic [CMD_W-1:0]              req_command,
   input  logic [ELAPSED_W-1:0]          req_elapsed,
   input  logic signed [REQ_SCALE_W-1:0] req_scale,
   input  logic signed [REQ_TIME_W-1:0]  req_duration,
   input  logic signed [REQ_TIME_W-1:0]  req_ramp_in,
   input  logic signed [REQ_TIME_W-1:0]  req_ramp_out,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [SCALE_BITS-1:0]         rsp_current_scale,
   output logic [PHASE_W-1:0]            rsp_phase
);

   // Clamp a signed time to 0..TIME_MAX
   function automatic logic [TIME_BITS-1:0] time_clamp(input logic signed [REQ_TIME_W-1:0] v);
      logic [TIME_BITS-1:0] r;
      if (v[REQ_TIME_W-1]) begin
         r = '0;
      end else if (v > $signed(TIME_MAX)) begin
         r = TIME_MAX[TIME_BITS-1:0];
      end else begin
         r = v[TIME_BITS-1:0];
      end
      return r;
   endfunction

   // Latched transaction
   sme_command_type        cmd_ff, cmd_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic [SCALE_BITS-1:0]  goal_req_ff, goal_req_in;
   logic [TIME_BITS-1:0]   dur_req_ff, dur_req_in;
   logic [TIME_BITS-1:0]   rin_req_ff, rin_req_in;
   logic [TIME_BITS-1:0]   rout_req_ff, rout_req_in;

   // Envelope state
   sme_phase_type          phase_ff, phase_in;
   logic [TIMER_BITS-1:0]  timer_ff, timer_in;
   logic [SCALE_BITS-1:0]  scale_now_ff, scale_now_in;
   logic [SCALE_BITS-1:0]  goal_ff, goal_in;
   logic [TIME_BITS-1:0]   hold_ff, hold_in;
   logic [TIME_BITS-1:0]   in_time_ff, in_time_in;
   logic [TIME_BITS-1:0]   out_time_ff, out_time_in;

   // Divider and multiplier
   logic [TIME_BITS-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCALE_BITS-1:0]  rsp_scale_ff, rsp_scale_in;
   sme_phase_type          rsp_phase_ff, rsp_phase_in;

   // Working signals
   logic [TIMER_BITS:0]    tsum_wide;
   logic [TIMER_BITS-1:0]  tsum;
   logic [TIME_BITS-1:0]   ramp;
   logic                   is_tick;
   logic                   is_blend;
   logic                   ratio_div;
   logic [TIME_BITS:0]     rem2;
   logic [TIME_BITS:0]     diff;
   logic                   ge;
   logic [SCALE_BITS-1:0]  t_ratio;
   logic [SCALE_BITS-1:0]  span;
   logic [SCALE_BITS-1:0]  part;
   logic [TIME_BITS-1:0]   quarter;
   logic [FIFTH_PROD_BITS-1:0] fifth_prod;

   // Latch and clean up the accepted transaction
   always_comb begin
      cmd_in      = cmd_ff;
      elapsed_in  = elapsed_ff;
      goal_req_in = goal_req_ff;
      dur_req_in  = dur_req_ff;
      rin_req_in  = rin_req_ff;
      rout_req_in = rout_req_ff;
      if (cmd.load) begin
         cmd_in     = sme_command_type'(req_command);
         elapsed_in = req_elapsed;
         if (req_scale[REQ_SCALE_W-1]) begin
            goal_req_in = '0;
         end else if (req_scale > $signed({1'b0, ONE})) begin
            goal_req_in = ONE;
         end else begin
            goal_req_in = req_scale[SCALE_BITS-1:0];
         end
         dur_req_in  = time_clamp(req_duration);
         rin_req_in  = time_clamp(req_ramp_in);
         rout_req_in = time_clamp(req_ramp_out);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_UNUSED;
      end else begin
         cmd_ff <= cmd_in;
      end
      elapsed_ff  <= elapsed_in;
      goal_req_ff <= goal_req_in;
      dur_req_ff  <= dur_req_in;
      rin_req_ff  <= rin_req_in;
      rout_req_ff <= rout_req_in;
   end

   // Saturating timer advance and ramp selection
   assign tsum_wide = {1'b0, timer_ff} + (TIMER_BITS + 1)'(elapsed_ff);
   assign tsum      = tsum_wide[TIMER_BITS] ? {TIMER_BITS{1'b1}} : tsum_wide[TIMER_BITS-1:0];
   assign ramp      = (phase_ff == PH_BLEND_IN) ? in_time_ff : out_time_ff;
   assign is_tick   = (cmd_ff == CMD_TICK);
   assign is_blend  = (phase_ff == PH_BLEND_IN) || (phase_ff == PH_BLEND_OUT);

   // A ratio below one only when the timer has not yet reached the ramp time
   assign ratio_div = is_tick && is_blend && (ramp != '0) && (tsum < {1'b0, ramp});

   assign stat.need_div = ratio_div;
   assign stat.div_last = (cnt_ff == '0);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // Restoring divider, one quotient bit a cycle
   assign rem2    = {rem_ff, 1'b0};
   assign ge      = (rem2 >= {1'b0, ramp});
   assign diff    = rem2 - {1'b0, ramp};

   // Four fifths of the hold time by reciprocal multiplication
   assign fifth_prod = FIFTH_PROD_BITS'({dur_req_ff, 2'b00}) * FIFTH_PROD_BITS'(FIFTH_MUL);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.div_init) begin
         quo_in = '0;
         rem_in = tsum[TIME_BITS-1:0];
         cnt_in = CNT_BITS'(SCALE_FRAC_BITS - 1);
      end else if (cmd.div_step) begin
         rem_in = ge ? diff[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
      end else if (cmd.mul && (cmd_ff == CMD_SIMPLE)) begin
         quo_in = DIVIDEND_BITS'(fifth_prod[FIFTH_SHIFT +: TIME_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Scale the span by the blend ratio
   assign t_ratio = ratio_div ? {1'b0, quo_ff[SCALE_FRAC_BITS-1:0]} : ONE;
   assign span    = ONE - goal_ff;
   assign prod_in = cmd.mul ? (PROD_BITS'(span) * PROD_BITS'(t_ratio)) : prod_ff;
   assign part    = prod_ff[SCALE_FRAC_BITS +: SCALE_BITS];
   assign quarter = dur_req_ff >> 2;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Work out the envelope state after this transaction
   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      scale_now_in = scale_now_ff;
      goal_in      = goal_ff;
      hold_in      = hold_ff;
      in_time_in   = in_time_ff;
      out_time_in  = out_time_ff;
      unique case (cmd_ff)
         CMD_SIMPLE: begin
            goal_in    = goal_req_ff;
            hold_in    = dur_req_ff;
            in_time_in = (quarter < IN_CAP) ? quarter : IN_CAP;
            if (quo_ff < OUT_LOW) begin
               out_time_in = OUT_LOW[TIME_BITS-1:0];
            end else if (quo_ff > OUT_HIGH) begin
               out_time_in = OUT_HIGH[TIME_BITS-1:0];
            end else begin
               out_time_in = quo_ff[TIME_BITS-1:0];
            end
            timer_in = '0;
            phase_in = PH_BLEND_IN;
         end
         CMD_ADVANCED: begin
            goal_in     = goal_req_ff;
            hold_in     = dur_req_ff;
            in_time_in  = rin_req_ff;
            out_time_in = rout_req_ff;
            timer_in    = '0;
            phase_in    = PH_BLEND_IN;
         end
         CMD_TICK: begin
            unique case (phase_ff)
               PH_BLEND_IN: begin
                  timer_in     = tsum;
                  scale_now_in = ONE - part;
                  if (!ratio_div) begin
                     phase_in = PH_HOLD;
                     timer_in = '0;
                  end
               end
               PH_HOLD: begin
                  timer_in     = tsum;
                  scale_now_in = goal_ff;
                  if (tsum >= {1'b0, hold_ff}) begin
                     phase_in = PH_BLEND_OUT;
                     timer_in = '0;
                  end
               end
               PH_BLEND_OUT: begin
                  timer_in     = tsum;
                  scale_now_in = goal_ff + part;
                  if (!ratio_div) begin
                     phase_in     = PH_NONE;
                     timer_in     = '0;
                     scale_now_in = ONE;
                  end
               end
               default: begin
                  scale_now_in = ONE;
               end
            endcase
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Commit the envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NONE;
         timer_ff     <= '0;
         scale_now_ff <= ONE;
         goal_ff      <= ONE;
         hold_ff      <= '0;
         in_time_ff   <= '0;
         out_time_ff  <= '0;
      end else if (cmd.commit) begin
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         scale_now_ff <= scale_now_in;
         goal_ff      <= goal_in;
         hold_ff      <= hold_in;
         in_time_ff   <= in_time_in;
         out_time_ff  <= out_time_in;
      end
   end

   // Result register: load on commit, drop when taken
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_scale_in = cmd.commit ? scale_now_in : rsp_scale_ff;
   assign rsp_phase_in = cmd.commit ? phase_in : rsp_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_scale_ff <= rsp_scale_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_scale = rsp_scale_ff;
   assign rsp_phase         = rsp_phase_ff;

endmodule

`default_nettype wire

### src/slow_motion_envelope_unit.sv
// Top level of the slow-motion envelope unit: controller plus datapath.
//
// Attack-hold-release envelope for a playback rate factor (Q1.16, 65536 = 1.0).
// The request channel (req_valid / req_stall) carries one transaction per item:
// a tick that advances the envelope by req_elapsed microseconds, or a simple or
// advanced slow request that sets the target scale and the ramp and hold times.
// Every transaction returns one result on the response channel (rsp_valid /
// rsp_stall): the current scale and the phase after that transaction.
// One transaction is worked on at a time. Requests, ticks that need no ratio and
// unused commands pass from acceptance through prepare, multiply and commit; a
// tick mid-ramp adds a 16-step restoring divide of the timer by the ramp time
// between prepare and multiply. The next transaction is taken on the cycle
// after the result is registered.
// A result waiting in the output register does not block the next
// transaction; only the commit of the following result waits while rsp_stall
// holds the earlier one. Reset returns the envelope to phase none at scale 1.0
// with all times cleared, and empties the output register.
`default_nettype none

module slow_motion_envelope_unit import sme_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [CMD_W-1:0]              req_command,
   input  logic [ELAPSED_W-1:0]          req_elapsed,
   input  logic signed [REQ_SCALE_W-1:0] req_scale,
   input  logic signed [REQ_TIME_W-1:0]  req_duration,
   input  logic signed [REQ_TIME_W-1:0]  req_ramp_in,
   input  logic signed [REQ_TIME_W-1:0]  req_ramp_out,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [SCALE_BITS-1:0]         rsp_current_scale,
   output logic [PHASE_W-1:0]            rsp_phase
);

   sme_cmd_type  cmd;
   sme_stat_type stat;

   // Sequence each transaction
   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the envelope state and compute
   sme_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_command       (req_command),
      .req_elapsed       (req_elapsed),
      .req_scale         (req_scale),
      .req_duration      (req_duration),
      .req_ramp_in       (req_ramp_in),
      .req_ramp_out      (req_ramp_out),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_current_scale (rsp_current_scale),
      .rsp_phase         (rsp_phase)
   );

endmodule

`default_nettype wire
